// ----- hw/rtl/tlb_refill_round_robin_assert.svh -----
`ifndef TLB_REFILL_ROUND_ROBIN_ASSERT_SVH
`define TLB_REFILL_ROUND_ROBIN_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TLBRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TLBRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tlbrr_pkg.sv -----
`timescale 1ns / 1ps

package tlbrr_pkg;

  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 20;
  localparam int REQ_W   = 2;
  localparam int EVENT_W = 3;
  localparam int SLOT_W  = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD     = 2'd0,
    REQ_INV_ALL  = 2'd1,
    REQ_INV_PAGE = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_LOAD_FREE    = 3'd0,
    EV_LOAD_REPLACE = 3'd1,
    EV_INV_ALL      = 3'd2,
    EV_INV_PAGE     = 3'd3,
    EV_NOT_PRESENT  = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PAGE
  } state_t;

  // one word of the entry memory
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               writable;
  } entry_t;

endpackage

// ----- hw/rtl/tlb_refill_round_robin.sv -----
`timescale 1ns / 1ps

// TLB entry manager with round-robin replacement. A request is taken at a
// rising edge with start high and busy low; its single result (if any) shows
// on out_event_res / out_slot for exactly one cycle with out_valid high, and
// the receiver cannot stall it, so it must take every result the cycle it
// appears. Invalidate-all finishes in the cycle of the transfer and its
// result follows in the next cycle. A load keeps busy high while it searches
// for a free slot, stepping one valid bit per cycle. The load that finds no
// free slot walks all ENTRIES valid bits, sets the full flag and replaces the
// victim; every load after that replaces the victim with no search.
// Invalidate-page checks one entry per cycle through the read port of the
// entry memory, until it finds the page or has checked all ENTRIES entries.
// The unused request code gives no result and never raises busy. After
// reset the table is empty at once; no clearing pass is needed.
module tlb_refill_round_robin #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tlbrr_pkg::REQ_W-1:0]   in_req_type,
  input  logic [tlbrr_pkg::PAGE_W-1:0]  in_page_number,
  input  logic [tlbrr_pkg::FRAME_W-1:0] in_frame_number,
  input  logic                          in_read_only,
  output logic                          out_valid,
  output logic [tlbrr_pkg::EVENT_W-1:0] out_event_res,
  output logic [tlbrr_pkg::SLOT_W-1:0]  out_slot
);

  import tlbrr_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // index widened to at least the slot field, so the low bits can be taken
  localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  // slot field carries the low bits of the entry index
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
    logic [XW-1:0] ext;
    ext = XW'(idx);
    return ext[SLOT_W-1:0];
  endfunction

  // control state
  state_t              state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;      // scan position
  logic [IW-1:0]       vict_r, vict_nxt;    // round-robin victim pointer
  logic                full_r, full_nxt;    // sticky, cleared only by reset
  logic [ENTRIES-1:0]  valid_r, valid_nxt;  // per-entry valid marks

  // captured request
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic                ro_r, ro_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  event_t              out_event_r, out_event_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  // entry memory port
  logic                we;
  logic [IW-1:0]       waddr;
  entry_t              wdata;
  logic                re;
  logic [IW-1:0]       raddr;
  logic [$bits(entry_t)-1:0] rdata_raw;
  entry_t              rdata;

  logic                do_replace;

  tlbrr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  // a load always writes the captured request
  assign wdata = '{page: page_r, frame: frame_r, writable: ~ro_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      vict_r      <= '0;
      full_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      vict_r      <= vict_nxt;
      full_r      <= full_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    frame_r     <= frame_nxt;
    ro_r        <= ro_nxt;
    out_event_r <= out_event_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    vict_nxt      = vict_r;
    full_nxt      = full_r;
    valid_nxt     = valid_r;
    page_nxt      = page_r;
    frame_nxt     = frame_r;
    ro_nxt        = ro_r;
    out_valid_nxt = 1'b0;
    out_event_nxt = out_event_r;
    out_slot_nxt  = out_slot_r;
    we            = 1'b0;
    waddr         = idx_r;
    re            = 1'b0;
    raddr         = idx_r + 1'b1;
    do_replace    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt  = in_page_number;
          frame_nxt = in_frame_number;
          ro_nxt    = in_read_only;
          case (req_t'(in_req_type))
            REQ_LOAD: begin
              idx_nxt   = '0;
              state_nxt = ST_LOAD;
            end
            REQ_INV_ALL: begin
              // only the valid marks go, entry contents stay
              valid_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_event_nxt = EV_INV_ALL;
              out_slot_nxt  = '0;
            end
            REQ_INV_PAGE: begin
              // prime the read of entry 0
              re        = 1'b1;
              raddr     = '0;
              idx_nxt   = '0;
              state_nxt = ST_PAGE;
            end
            default: begin
              // unused code: no change, no result
            end
          endcase
        end
      end

      ST_LOAD: begin
        if (full_r) begin
          do_replace = 1'b1;
        end else if (!valid_r[idx_r]) begin
          // first free slot found
          we             = 1'b1;
          waddr          = idx_r;
          valid_nxt[idx_r] = 1'b1;
          out_valid_nxt  = 1'b1;
          out_event_nxt  = EV_LOAD_FREE;
          out_slot_nxt   = to_slot(idx_r);
          state_nxt      = ST_IDLE;
        end else if (idx_r == LAST) begin
          // table just filled up, switch to round-robin for good
          full_nxt   = 1'b1;
          do_replace = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end

        if (do_replace) begin
          we                = 1'b1;
          waddr             = vict_r;
          valid_nxt[vict_r] = 1'b1;
          out_valid_nxt     = 1'b1;
          out_event_nxt     = EV_LOAD_REPLACE;
          out_slot_nxt      = to_slot(vict_r);
          vict_nxt          = (vict_r == LAST) ? '0 : vict_r + 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      ST_PAGE: begin
        // rdata holds entry idx_r, read in the previous cycle
        if (valid_r[idx_r] && (rdata.page == page_r)) begin
          valid_nxt[idx_r] = 1'b0;
          out_valid_nxt    = 1'b1;
          out_event_nxt    = EV_INV_PAGE;
          out_slot_nxt     = to_slot(idx_r);
          state_nxt        = ST_IDLE;
        end else if (idx_r == LAST) begin
          out_valid_nxt = 1'b1;
          out_event_nxt = EV_NOT_PRESENT;
          out_slot_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = idx_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;
  assign out_slot      = out_slot_r;

endmodule

// ----- hw/rtl/tlbrr_ram.sv -----
`timescale 1ns / 1ps

module tlbrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/tlbrr_checker.sv -----
`timescale 1ns / 1ps

`include "tlb_refill_round_robin_assert.svh"

module tlbrr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [tlbrr_pkg::REQ_W-1:0]   in_req_type,
  input logic                          out_valid,
  input logic [tlbrr_pkg::EVENT_W-1:0] out_event_res,
  input logic [tlbrr_pkg::SLOT_W-1:0]  out_slot
);

  import tlbrr_pkg::*;

  // invalidate-all answers in the very next cycle with slot 0
  `TLBRR_ASSERT_NEXT(a_inv_all_result, start && !busy && (in_req_type == REQ_INV_ALL), out_valid && (out_event_res == EV_INV_ALL) && (out_slot == '0), "invalidate-all result missing or wrong")

  // unused request code leaves the block idle and silent
  `TLBRR_ASSERT_NEXT(a_unused_silent, start && !busy && (in_req_type == REQ_UNUSED), !out_valid && !busy, "unused request code had an effect")

  // a load always goes busy after it is taken, to work on the entry memory
  `TLBRR_ASSERT_NEXT(a_load_busy, start && !busy && (in_req_type == REQ_LOAD), busy, "load did not enter its search")

  // only defined event codes, and slot 0 where no entry is named
  `TLBRR_ASSERT_NOW(a_event_slot, out_valid, (out_event_res <= EV_NOT_PRESENT) && (((out_event_res != EV_INV_ALL) && (out_event_res != EV_NOT_PRESENT)) || (out_slot == '0)), "bad event code or nonzero slot")

endmodule

bind tlb_refill_round_robin tlbrr_checker u_tlbrr_checker (.*);
